>>> hw/rtl/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

   // Final status codes reported with the end of a string.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // Byte classification limits.
   localparam logic [7:0] ASCII_TOP      = 8'h7F;
   localparam logic [7:0] LEAD_MIN       = 8'hC2;
   localparam logic [7:0] LEAD_MAX       = 8'hF4;
   localparam logic [7:0] LEAD3_MIN      = 8'hE0;
   localparam logic [7:0] LEAD4_MIN      = 8'hF0;
   localparam logic [7:0] CONT_LO        = 8'h80;
   localparam logic [7:0] CONT_HI        = 8'hBF;

   // Leads with a restricted second byte, and the limits that apply.
   localparam logic [7:0] LEAD_E0        = 8'hE0;
   localparam logic [7:0] LEAD_ED        = 8'hED;
   localparam logic [7:0] LEAD_F0        = 8'hF0;
   localparam logic [7:0] LEAD_F4        = 8'hF4;
   localparam logic [7:0] E0_SECOND_LO   = 8'hA0;
   localparam logic [7:0] ED_SECOND_HI   = 8'h9F;
   localparam logic [7:0] F0_SECOND_LO   = 8'h90;
   localparam logic [7:0] F4_SECOND_HI   = 8'h8F;

   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned COUNT_OUT_W = 16;

   // One input word held in the input register.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [CP_WIDTH-1:0]    code_point;
      logic                   has_char;
      logic                   end_of_string;
      logic [1:0]             status;
      logic [COUNT_OUT_W-1:0] char_count;
   } rsp_word_type;

   // Handshake between the decoder and the two registers around it.
   typedef struct packed {
      logic advance;
      logic push;
   } dec_ctrl_type;

endpackage

`default_nettype wire

>>> hw/rtl/utf8d_in_stage.sv
`default_nettype none

module utf8d_in_stage (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  utf8d_pkg::req_word_type     in_word,
   input  wire                         advance,
   output logic                        stage_valid,
   output utf8d_pkg::req_word_type     stage_word
);

   logic                    valid_ff;
   logic                    valid_in;
   utf8d_pkg::req_word_type word_ff;
   logic                    load;

   // A new word is taken when the register is empty or drains this cycle.
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= in_word;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/utf8d_decode.sv
`default_nettype none

module utf8d_decode #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire  [15:0]                 csr_wr_data,
   input  wire                         stage_valid,
   input  utf8d_pkg::req_word_type     stage_word,
   input  wire                         out_ready,
   output utf8d_pkg::dec_ctrl_type     ctrl,
   output utf8d_pkg::rsp_word_type     result
);

   localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int unsigned CPW   = utf8d_pkg::CP_WIDTH;

   logic [15:0]           max_chars_ff;
   logic [1:0]            pending_ff,  pending_in;
   logic                  second_ff,   second_in;
   logic [7:0]            lead_ff,     lead_in;
   logic [CPW-1:0]        acc_ff,      acc_in;
   logic [1:0]            err_ff,      err_in;
   logic [COUNT_BITS-1:0] count_ff,    count_in;

   logic [7:0]            b;
   logic                  last;
   logic                  complete;
   logic                  has;
   logic                  emit;
   logic [CPW-1:0]        cp;
   logic [7:0]            lo;
   logic [7:0]            hi;
   logic                  full;
   logic [CMP_W-1:0]      count_ext;
   logic [CMP_W-1:0]      max_ext;
   logic [CMP_W-1:0]      count_out_ext;

   assign b    = stage_word.data_byte;
   assign last = stage_word.last_byte;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= 16'hFFFF;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   // The destination is full at max_chars or when the counter saturates.
   assign count_ext = CMP_W'(count_ff);
   assign max_ext   = CMP_W'(max_chars_ff);
   assign full      = (count_ext >= max_ext) || (&count_ff);

   // Allowed range of a continuation byte, narrowed right after some leads.
   always_comb begin
      lo = utf8d_pkg::CONT_LO;
      hi = utf8d_pkg::CONT_HI;
      if (second_ff) begin
         case (lead_ff)
            utf8d_pkg::LEAD_E0: lo = utf8d_pkg::E0_SECOND_LO;
            utf8d_pkg::LEAD_ED: hi = utf8d_pkg::ED_SECOND_HI;
            utf8d_pkg::LEAD_F0: lo = utf8d_pkg::F0_SECOND_LO;
            utf8d_pkg::LEAD_F4: hi = utf8d_pkg::F4_SECOND_HI;
            default: ;
         endcase
      end
   end

   // Decode one byte against the per-string state.
   always_comb begin
      pending_in = pending_ff;
      second_in  = second_ff;
      lead_in    = lead_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      count_in   = count_ff;
      complete   = 1'b0;
      has        = 1'b0;
      cp         = '0;
      if (err_ff == utf8d_pkg::STATUS_OK) begin
         if (pending_ff == 2'd0) begin
            if (b <= utf8d_pkg::ASCII_TOP) begin
               cp       = CPW'(b);
               complete = 1'b1;
            end else if (b < utf8d_pkg::LEAD_MIN || b > utf8d_pkg::LEAD_MAX) begin
               err_in = utf8d_pkg::STATUS_ILLEGAL;
            end else if (b < utf8d_pkg::LEAD3_MIN) begin
               pending_in = 2'd1;
               acc_in     = CPW'(b[4:0]);
               lead_in    = b;
               second_in  = 1'b1;
            end else if (b < utf8d_pkg::LEAD4_MIN) begin
               pending_in = 2'd2;
               acc_in     = CPW'(b[3:0]);
               lead_in    = b;
               second_in  = 1'b1;
            end else begin
               pending_in = 2'd3;
               acc_in     = CPW'(b[2:0]);
               lead_in    = b;
               second_in  = 1'b1;
            end
         end else begin
            if (b < lo || b > hi) begin
               err_in     = utf8d_pkg::STATUS_ILLEGAL;
               pending_in = 2'd0;
               second_in  = 1'b0;
            end else begin
               acc_in     = {acc_ff[CPW-7:0], b[5:0]};
               pending_in = pending_ff - 2'd1;
               second_in  = 1'b0;
               if (pending_ff == 2'd1) begin
                  cp       = acc_in;
                  complete = 1'b1;
               end
            end
         end
         // A finished character is stored only while there is room.
         if (complete) begin
            if (full) begin
               err_in = utf8d_pkg::STATUS_FULL;
               cp     = '0;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
               has      = 1'b1;
            end
         end
         if (last && err_in == utf8d_pkg::STATUS_OK && pending_in != 2'd0) begin
            err_in     = utf8d_pkg::STATUS_TRUNCATED;
            pending_in = 2'd0;
         end
      end
   end

   // A word yields a result when it carries a character or ends the string.
   assign emit         = has || last;
   assign ctrl.advance = stage_valid && (!emit || out_ready);
   assign ctrl.push    = stage_valid && emit && out_ready;

   assign count_out_ext        = CMP_W'(count_in);
   assign result.code_point    = cp;
   assign result.has_char      = has;
   assign result.end_of_string = last;
   assign result.status        = last ? err_in : utf8d_pkg::STATUS_OK;
   assign result.char_count    = count_out_ext[15:0];

   // Per-string state; the last word of a string clears it.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         second_ff  <= 1'b0;
         lead_ff    <= '0;
         acc_ff     <= '0;
         err_ff     <= utf8d_pkg::STATUS_OK;
         count_ff   <= '0;
      end else if (ctrl.advance) begin
         if (last) begin
            pending_ff <= 2'd0;
            second_ff  <= 1'b0;
            lead_ff    <= '0;
            acc_ff     <= '0;
            err_ff     <= utf8d_pkg::STATUS_OK;
            count_ff   <= '0;
         end else begin
            pending_ff <= pending_in;
            second_ff  <= second_in;
            lead_ff    <= lead_in;
            acc_ff     <= acc_in;
            err_ff     <= err_in;
            count_ff   <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/utf8d_out_reg.sv
`default_nettype none

module utf8d_out_reg (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  utf8d_pkg::rsp_word_type     push_word,
   output logic                        can_accept,
   output logic                        out_valid,
   input  wire                         out_ready,
   output utf8d_pkg::rsp_word_type     out_word
);

   logic                    valid_ff;
   logic                    valid_in;
   utf8d_pkg::rsp_word_type word_ff;

   // Room for a new result when empty or when the held one leaves now.
   assign can_accept = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff <= push_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_utf32_decoder.sv
// Channel   Direction  Width  Contents
// req       in         8+1    tdata: data_byte; tlast: last_byte
// rsp       out        40+3+1 tdata: code_point, char_count; tuser: has_char, status;
//                             tlast: end_of_string
// csr       in         16     max_chars, written when csr_wr_en is high
//
// One byte is accepted every clock unless a stall holds it. Each byte first waits in
// the input register, then the decode logic loads its result into the result register.
// Reset clears the decode state and sets max_chars to 65535.
// When rsp_tready is low, a held result stalls the byte behind it only if that byte
// also yields a result; bytes that yield none keep flowing.
`default_nettype none

module utf8_to_utf32_decoder #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   // Byte stream.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,  // [7:0] data_byte
   input  wire         req_tlast,  // last_byte
   // Code point stream.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // [20:0] code_point, [36:21] char_count, [39:37] zero
   output logic [2:0]  rsp_tuser,  // [0] has_char, [2:1] status
   output logic        rsp_tlast,  // end_of_string
   // Capacity register.
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);

   utf8d_pkg::req_word_type in_word;
   utf8d_pkg::req_word_type stage_word;
   utf8d_pkg::rsp_word_type dec_word;
   utf8d_pkg::rsp_word_type out_word;
   utf8d_pkg::dec_ctrl_type ctrl;
   logic                    stage_valid;
   logic                    out_can_accept;

   assign in_word.data_byte = req_tdata;
   assign in_word.last_byte = req_tlast;

   // Input register.
   utf8d_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_word     (in_word),
      .advance     (ctrl.advance),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   // Validation and code point assembly.
   utf8d_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .out_ready   (out_can_accept),
      .ctrl        (ctrl),
      .result      (dec_word)
   );

   // Result register.
   utf8d_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (ctrl.push),
      .push_word  (dec_word),
      .can_accept (out_can_accept),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

   assign rsp_tdata = {3'b000, out_word.char_count, out_word.code_point};
   assign rsp_tuser = {out_word.status, out_word.has_char};
   assign rsp_tlast = out_word.end_of_string;

endmodule

`default_nettype wire

>>> tb/utf8_to_utf32_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_to_utf32_decoder_tb;

   localparam int unsigned COUNT_BITS    = 16;
   localparam int unsigned COUNT_LIMIT   = (1 << COUNT_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_BYTES   = 238;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned PRINT_LIMIT   = 40;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Bytes waiting to be sent, and code point words still to come back.
   utf8d_pkg::req_word_type pending_bytes[$];
   utf8d_pkg::rsp_word_type expected_words[$];
   logic [7:0]              str_bytes[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned bytes_queued   = 0;

   // Decoder state as the predictor sees it.
   logic [15:0]  dec_max     = 16'hFFFF;
   logic [1:0]   dec_pending = '0;
   logic         dec_second  = 1'b0;
   logic [7:0]   dec_lead    = '0;
   logic [20:0]  dec_acc     = '0;
   logic [1:0]   dec_err     = utf8d_pkg::STATUS_OK;
   int unsigned  dec_written = 0;

   utf8_to_utf32_decoder #(
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predict the word, if any, that one accepted byte causes.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [20:0]             cp;
      logic                    has;
      logic                    complete;
      logic [7:0]              lo;
      logic [7:0]              hi;
      utf8d_pkg::rsp_word_type w;
      cp       = '0;
      has      = 1'b0;
      complete = 1'b0;
      if (dec_err == utf8d_pkg::STATUS_OK) begin
         if (dec_pending == 2'd0) begin
            if (b <= utf8d_pkg::ASCII_TOP) begin
               cp       = {13'b0, b};
               complete = 1'b1;
            end else if (b < utf8d_pkg::LEAD_MIN || b > utf8d_pkg::LEAD_MAX) begin
               dec_err = utf8d_pkg::STATUS_ILLEGAL;
            end else begin
               dec_lead   = b;
               dec_second = 1'b1;
               if (b < utf8d_pkg::LEAD3_MIN) begin
                  dec_pending = 2'd1;
                  dec_acc     = {16'b0, b[4:0]};
               end else if (b < utf8d_pkg::LEAD4_MIN) begin
                  dec_pending = 2'd2;
                  dec_acc     = {17'b0, b[3:0]};
               end else begin
                  dec_pending = 2'd3;
                  dec_acc     = {18'b0, b[2:0]};
               end
            end
         end else begin
            // The byte right after some leads has a narrower range.
            lo = utf8d_pkg::CONT_LO;
            hi = utf8d_pkg::CONT_HI;
            if (dec_second) begin
               case (dec_lead)
                  utf8d_pkg::LEAD_E0: lo = utf8d_pkg::E0_SECOND_LO;
                  utf8d_pkg::LEAD_ED: hi = utf8d_pkg::ED_SECOND_HI;
                  utf8d_pkg::LEAD_F0: lo = utf8d_pkg::F0_SECOND_LO;
                  utf8d_pkg::LEAD_F4: hi = utf8d_pkg::F4_SECOND_HI;
                  default: ;
               endcase
            end
            if (b < lo || b > hi) begin
               dec_err     = utf8d_pkg::STATUS_ILLEGAL;
               dec_pending = 2'd0;
               dec_second  = 1'b0;
            end else begin
               dec_acc     = {dec_acc[14:0], b[5:0]};
               dec_pending = dec_pending - 2'd1;
               dec_second  = 1'b0;
               if (dec_pending == 2'd0) begin
                  cp       = dec_acc;
                  complete = 1'b1;
               end
            end
         end
         if (complete) begin
            if (dec_written >= dec_max || dec_written >= COUNT_LIMIT) begin
               dec_err = utf8d_pkg::STATUS_FULL;
               cp      = '0;
            end else begin
               dec_written++;
               has = 1'b1;
            end
         end
         if (last && dec_err == utf8d_pkg::STATUS_OK && dec_pending != 2'd0) begin
            dec_err     = utf8d_pkg::STATUS_TRUNCATED;
            dec_pending = 2'd0;
         end
      end
      if (has || last) begin
         w.code_point    = has ? cp : '0;
         w.has_char      = has;
         w.end_of_string = last;
         w.status        = last ? dec_err : utf8d_pkg::STATUS_OK;
         w.char_count    = dec_written[15:0];
         expected_words.push_back(w);
      end
      if (last) begin
         dec_pending = '0;
         dec_second  = 1'b0;
         dec_lead    = '0;
         dec_acc     = '0;
         dec_err     = utf8d_pkg::STATUS_OK;
         dec_written = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   // Hand the string being built to the driver, marking its final byte.
   task automatic queue_string();
      utf8d_pkg::req_word_type item;
      for (int i = 0; i < str_bytes.size(); i++) begin
         item.data_byte = str_bytes[i];
         item.last_byte = (i == str_bytes.size() - 1);
         pending_bytes.push_back(item);
         bytes_queued++;
      end
      str_bytes.delete();
   endtask

   // Wait until every byte has gone in and every word has come out, then let
   // the pipeline settle, since the final bytes may have caused no word.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: offer the next byte, or hold off at random.
   always @(posedge clock) begin : drive_proc
      utf8d_pkg::req_word_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.data_byte;
               req_tlast  <= item.last_byte;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and check each word against the oldest prediction.
   always @(posedge clock) begin : watch_proc
      utf8d_pkg::rsp_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[20:0], 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[20:0] !== want.code_point)
                  report_mismatch("code_point", rsp_tdata[20:0], want.code_point);
               if (rsp_tuser[0] !== want.has_char)
                  report_mismatch("has_char", rsp_tuser[0], want.has_char);
               if (rsp_tlast !== want.end_of_string)
                  report_mismatch("end_of_string", rsp_tlast, want.end_of_string);
               if (rsp_tuser[2:1] !== want.status)
                  report_mismatch("status", rsp_tuser[2:1], want.status);
               if (rsp_tdata[36:21] !== want.char_count)
                  report_mismatch("char_count", rsp_tdata[36:21], want.char_count);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_to_utf32_decoder_tb: done, errors");
         $finish;
      end
   end

   // Stimulus: one phase per capacity setting and idling pattern.
   initial begin
      int unsigned  phase_cap[PHASE_COUNT];
      int unsigned  cap;
      int unsigned  start;
      int unsigned  shape;
      int unsigned  n;
      logic [20:0]  cp;
      phase_cap = '{65535, 0, 1, 3, 0, 65535, 0, 7};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();
         cap = phase_cap[p];
         if (p == 4)
            cap = $urandom_range(2, 12);
         else if (p == 6)
            cap = $urandom_range(0, 5);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= cap[15:0];
         dec_max      = cap[15:0];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         @(negedge clock);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase

         if (p == 0) begin
            // Range ends of one and two byte forms; the last byte ends a character.
            str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
            queue_string();
            // Lowest and highest legal values behind each restricted lead.
            str_bytes = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                          8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
            queue_string();
            // Overlong, surrogate and out of range second bytes.
            str_bytes = '{8'hE0, 8'h9F};
            queue_string();
            str_bytes = '{8'hED, 8'hA0};
            queue_string();
            str_bytes = '{8'hF0, 8'h8F};
            queue_string();
            str_bytes = '{8'hF4, 8'h90};
            queue_string();
            // Illegal lead as the last byte beats truncation.
            str_bytes = '{8'h80};
            queue_string();
            // Bytes after the first error are ignored.
            str_bytes = '{8'hF5, 8'hFF, 8'hC1};
            queue_string();
            // String ends inside a sequence.
            str_bytes = '{8'hE2, 8'h82};
            queue_string();
         end

         // Mostly well-formed strings, some damaged, some pure noise.
         start = bytes_queued;
         while (bytes_queued - start < PHASE_BYTES) begin
            shape = $urandom_range(0, 99);
            if (shape < 12) begin
               n = $urandom_range(1, 6);
               repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  case ($urandom_range(0, 4))
                     0: cp = 21'($urandom_range(0, 'h7F));
                     1: cp = 21'($urandom_range('h80, 'h7FF));
                     2: begin
                        cp = 21'($urandom_range('h800, 'hFFFF));
                        if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
                           cp = cp - 21'h000800;
                     end
                     3: cp = 21'($urandom_range('h10000, 'h10FFFF));
                     default: begin
                        case ($urandom_range(0, 7))
                           0: cp = 21'h00007F;
                           1: cp = 21'h000080;
                           2: cp = 21'h0007FF;
                           3: cp = 21'h000800;
                           4: cp = 21'h00D7FF;
                           5: cp = 21'h00E000;
                           6: cp = 21'h00FFFF;
                           default: cp = 21'h10FFFF;
                        endcase
                     end
                  endcase
                  if (cp < 21'h000080) begin
                     str_bytes.push_back(cp[7:0]);
                  end else if (cp < 21'h000800) begin
                     str_bytes.push_back({3'b110, cp[10:6]});
                     str_bytes.push_back({2'b10, cp[5:0]});
                  end else if (cp < 21'h010000) begin
                     str_bytes.push_back({4'b1110, cp[15:12]});
                     str_bytes.push_back({2'b10, cp[11:6]});
                     str_bytes.push_back({2'b10, cp[5:0]});
                  end else begin
                     str_bytes.push_back({5'b11110, cp[20:18]});
                     str_bytes.push_back({2'b10, cp[17:12]});
                     str_bytes.push_back({2'b10, cp[11:6]});
                     str_bytes.push_back({2'b10, cp[5:0]});
                  end
               end
               if (shape >= 75) begin
                  case ($urandom_range(0, 2))
                     0: str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                           8'($urandom_range(0, 255));
                     1: repeat ($urandom_range(1, 2))
                           if (str_bytes.size() > 1)
                              void'(str_bytes.pop_back());
                     default: str_bytes.insert($urandom_range(0, str_bytes.size()),
                                               8'($urandom_range(0, 255)));
                  endcase
               end
            end
            queue_string();
         end
      end

      wait_until_drained();
      if (error_count == 0)
         $display("utf8_to_utf32_decoder_tb: done, clean");
      else
         $display("utf8_to_utf32_decoder_tb: done, errors");
      $finish;
   end

endmodule
